@@ rtl/accessory_dock_detector_defines.svh @@
// Assertion macros shared by the accessory dock detector RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef ACCESSORY_DOCK_DETECTOR_DEFINES_SVH
`define ACCESSORY_DOCK_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ADD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ADD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/add_pkg.sv @@
// Package of the accessory dock detector: beat types, codes and constants.
// No dependencies; used by the interface instances and the top level.
`timescale 1ns / 1ps
`default_nettype none

package add_pkg;

  // Converter sample width and default sample count per detection.
  localparam int unsigned ADC_BITS          = 12;
  localparam int unsigned SAMPLES_DEFAULT   = 5;

  // Configuration port shape.
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned CFG_W     = 12;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_TV_LO       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TV_HI       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LINEOUT_LO  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LINEOUT_HI  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CARMOUNT_LO = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CARMOUNT_HI = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_USB_LO      = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_USB_HI      = 3'd7;

  localparam logic [CFG_W-1:0] REG_RESET [NUM_REGS] = '{
    12'd2150, 12'd2350, 12'd1150, 12'd1350,
    12'd1650, 12'd1850, 12'd2700, 12'd2799
  };

  // Operation codes of an input beat.
  localparam logic [1:0] OP_DOCK_LINE  = 2'd0;
  localparam logic [1:0] OP_ID_LINE    = 2'd1;
  localparam logic [1:0] OP_ADC_SAMPLE = 2'd2;

  // Pin levels; a low pin means something is plugged in.
  localparam logic LEVEL_ATTACHED = 1'b0;
  localparam logic LEVEL_DETACHED = 1'b1;

  // Stored dock line state: low, high, or nothing seen yet.
  localparam logic [1:0] DOCK_LINE_LOW    = 2'd0;
  localparam logic [1:0] DOCK_LINE_UNSEEN = 2'd3;

  // Event kinds.
  localparam logic [1:0] EVT_NONE      = 2'd0;
  localparam logic [1:0] EVT_DOCK      = 2'd1;
  localparam logic [1:0] EVT_ACCESSORY = 2'd2;

  // Dock kinds.
  localparam logic [1:0] DOCK_NONE     = 2'd0;
  localparam logic [1:0] DOCK_DESKTOP  = 2'd1;
  localparam logic [1:0] DOCK_KEYBOARD = 2'd2;

  // Accessory kinds.
  localparam logic [1:0] ACC_UNKNOWN    = 2'd0;
  localparam logic [1:0] ACC_TV         = 2'd1;
  localparam logic [1:0] ACC_AUDIO_OUT  = 2'd2;
  localparam logic [1:0] ACC_CAR_HOLDER = 2'd3;

  // Status bit positions.
  localparam int unsigned ST_DESK     = 0;
  localparam int unsigned ST_KEYBOARD = 1;
  localparam int unsigned ST_CARMOUNT = 2;
  localparam int unsigned ST_TV       = 3;
  localparam int unsigned ST_LINEOUT  = 4;
  localparam int unsigned ST_HPD      = 5;
  localparam int unsigned STATUS_W    = 6;

  typedef struct packed {
    logic [1:0]          operation;
    logic                line_level;
    logic                keyboard_present;
    logic [ADC_BITS-1:0] adc_value;
    logic                hpd_active;
  } add_in_t;

  typedef struct packed {
    logic [1:0]          event_kind;
    logic                event_online;
    logic [1:0]          dock_kind;
    logic [1:0]          accessory_kind;
    logic                usb_host_attach;
    logic                tv_power;
    logic [STATUS_W-1:0] status_bits;
    logic [ADC_BITS-1:0] averaged_adc;
  } add_out_t;

  // Exclusive window test: lo < v < hi.
  function automatic logic in_window(input logic [ADC_BITS-1:0] v,
                                     input logic [CFG_W-1:0]    lo,
                                     input logic [CFG_W-1:0]    hi);
    return (lo < v) && (v < hi);
  endfunction

endpackage

`default_nettype wire

@@ rtl/add_stream_if.sv @@
// Valid/ready channel carrying one payload per beat.
// The payload type is set per instance, normally a struct from add_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface add_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/accessory_dock_detector.sv @@
// Accessory dock detector top level; uses add_pkg, add_stream_if and the assertion macros.
// Each result is registered: it appears on out_o in the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless out_o stalls; state update, trimmed mean and window tests share one pass.
// The output register frees in the cycle its beat is taken, so input backpressure is one deep.
// Reset (rst_ni low, asynchronous) restores window defaults and clears all tracking state.
`timescale 1ns / 1ps
`default_nettype none

`include "accessory_dock_detector_defines.svh"

module accessory_dock_detector #(
  parameter int unsigned SAMPLES_PER_DETECT = add_pkg::SAMPLES_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration writes: one register per cycle while cfg_we_i is high.
  input  wire logic                          cfg_we_i,
  input  wire logic [add_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [add_pkg::CFG_W-1:0]     cfg_wdata_i,
  // Item and result channels.
  add_stream_if.sink                         in_i,
  add_stream_if.source                       out_o
);
  import add_pkg::*;

  // Sample accumulator: room for SAMPLES_PER_DETECT full-scale samples.
  localparam int unsigned CNT_W   = $clog2(SAMPLES_PER_DETECT);
  localparam int unsigned SUM_W   = ADC_BITS + $clog2(SAMPLES_PER_DETECT);
  localparam logic [CNT_W-1:0] LAST_SAMPLE = CNT_W'(SAMPLES_PER_DETECT - 1);

  // Trimmed sum is divided by the number of kept samples through an exact
  // reciprocal: with shift SUM_W + ceil(log2 d), floor(x * ceil(2^s / d) / 2^s)
  // equals floor(x / d) for every x below 2^SUM_W.
  localparam int unsigned DIVISOR   = SAMPLES_PER_DETECT - 2;
  localparam int unsigned DIV_SHIFT = SUM_W + $clog2(DIVISOR);
  localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
  localparam longint unsigned RECIP_FULL =
    ((longint'(1) << DIV_SHIFT) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;

  // ---------------------------------------------------------------------
  // Window registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] win_q [NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        win_q[i] <= REG_RESET[i];
      end
    end else if (cfg_we_i) begin
      win_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------
  // Tracking state
  // ---------------------------------------------------------------------
  logic [1:0]          dock_line_q, dock_line_d;
  logic                id_line_q, id_line_d;
  logic [1:0]          dock_type_q, dock_type_d;
  logic [1:0]          acc_type_q, acc_type_d;
  logic [CNT_W-1:0]    samples_q, samples_d;
  logic                sampling_q, sampling_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [ADC_BITS-1:0] min_q, min_d;
  logic [ADC_BITS-1:0] max_q, max_d;
  logic                tv_power_q, tv_power_d;
  logic [ADC_BITS-1:0] last_mean_q, last_mean_d;

  // Result register.
  logic                out_valid_q;
  add_out_t            out_q, out_d;

  // Handshake: take a new beat whenever the result register is empty or
  // its current beat leaves in this cycle.
  logic in_fire;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // ---------------------------------------------------------------------
  // Sample accumulation and trimmed mean
  // ---------------------------------------------------------------------
  logic                first_sample;
  logic [SUM_W-1:0]    acc_sum;
  logic [ADC_BITS-1:0] acc_min, acc_max;
  logic [SUM_W-1:0]    trimmed;
  logic [PROD_W-1:0]   mean_prod;
  logic [ADC_BITS-1:0] mean;

  always_comb begin
    first_sample = (samples_q == '0);
    if (first_sample) begin
      acc_sum = SUM_W'(in_i.payload.adc_value);
      acc_min = in_i.payload.adc_value;
      acc_max = in_i.payload.adc_value;
    end else begin
      acc_sum = sum_q + SUM_W'(in_i.payload.adc_value);
      acc_min = min_q;
      acc_max = max_q;
      // A new maximum never updates the minimum in the same beat.
      if (max_q < in_i.payload.adc_value) begin
        acc_max = in_i.payload.adc_value;
      end else if (min_q > in_i.payload.adc_value) begin
        acc_min = in_i.payload.adc_value;
      end
    end
    // From the second sample on, the sum covers min and max, so this does not wrap then.
    trimmed   = acc_sum - SUM_W'(acc_max) - SUM_W'(acc_min);
    mean_prod = PROD_W'(trimmed) * PROD_W'(RECIP);
    mean      = mean_prod[DIV_SHIFT +: ADC_BITS];
  end

  // ---------------------------------------------------------------------
  // Next state and result
  // ---------------------------------------------------------------------
  logic [1:0]          ev;
  logic                online;
  logic                usb;
  logic                dock_detached;
  logic [1:0]          classified;
  logic [STATUS_W-1:0] status;

  always_comb begin
    dock_line_d   = dock_line_q;
    id_line_d     = id_line_q;
    dock_type_d   = dock_type_q;
    acc_type_d    = acc_type_q;
    samples_d     = samples_q;
    sampling_d    = sampling_q;
    sum_d         = sum_q;
    min_d         = min_q;
    max_d         = max_q;
    tv_power_d    = tv_power_q;
    last_mean_d   = last_mean_q;
    ev            = EVT_NONE;
    online        = 1'b0;
    usb           = 1'b0;
    dock_detached = 1'b0;

    // Window classification in priority order TV, line-out, car-mount.
    if (in_window(mean, win_q[REG_TV_LO], win_q[REG_TV_HI])) begin
      classified = ACC_TV;
    end else if (in_window(mean, win_q[REG_LINEOUT_LO], win_q[REG_LINEOUT_HI])) begin
      classified = ACC_AUDIO_OUT;
    end else if (in_window(mean, win_q[REG_CARMOUNT_LO], win_q[REG_CARMOUNT_HI])) begin
      classified = ACC_CAR_HOLDER;
    end else begin
      classified = ACC_UNKNOWN;
    end

    case (in_i.payload.operation)
      OP_DOCK_LINE: begin
        if ({1'b0, in_i.payload.line_level} != dock_line_q) begin
          dock_line_d = {1'b0, in_i.payload.line_level};
          ev          = EVT_DOCK;
          if (in_i.payload.line_level == LEVEL_DETACHED) begin
            // Dock pulled: drop TV supply and forget the dock type.
            tv_power_d    = 1'b0;
            dock_detached = 1'b1;
            dock_type_d   = DOCK_NONE;
          end else begin
            online = 1'b1;
            if (in_i.payload.keyboard_present) begin
              dock_type_d = DOCK_KEYBOARD;
            end else begin
              // Desk dock drives the TV output.
              dock_type_d = DOCK_DESKTOP;
              tv_power_d  = 1'b1;
            end
          end
        end
      end
      OP_ID_LINE: begin
        if (in_i.payload.line_level != id_line_q) begin
          id_line_d = in_i.payload.line_level;
          samples_d = '0;
          if (in_i.payload.line_level == LEVEL_DETACHED) begin
            // Accessory gone: report with the kept type, abandon sampling.
            ev         = EVT_ACCESSORY;
            sampling_d = 1'b0;
            if (acc_type_q == ACC_TV) begin
              tv_power_d = 1'b0;
            end
          end else begin
            // ID line fell: start a fresh collection.
            sampling_d = 1'b1;
            sum_d      = '0;
            min_d      = '0;
            max_d      = '0;
          end
        end
      end
      OP_ADC_SAMPLE: begin
        if (sampling_q) begin
          sum_d = acc_sum;
          min_d = acc_min;
          max_d = acc_max;
          if (samples_q == LAST_SAMPLE) begin
            // Collection complete: classify the trimmed mean.
            sampling_d  = 1'b0;
            samples_d   = '0;
            last_mean_d = mean;
            ev          = EVT_ACCESSORY;
            if (mean != '0) begin
              online     = 1'b1;
              acc_type_d = classified;
              if (classified == ACC_TV) begin
                tv_power_d = 1'b1;
              end
              usb = in_window(mean, win_q[REG_USB_LO], win_q[REG_USB_HI]);
            end else if (acc_type_q == ACC_TV) begin
              // Zero mean reads as offline.
              tv_power_d = 1'b0;
            end
          end else begin
            samples_d = samples_q + CNT_W'(1);
          end
        end
      end
      default: begin
        // Unused operation code: hold everything.
      end
    endcase

    // Status reflects the state after this beat.
    status = '0;
    if (dock_line_d == DOCK_LINE_LOW) begin
      if (dock_type_d == DOCK_DESKTOP) begin
        status[ST_DESK] = 1'b1;
      end else if (dock_type_d == DOCK_KEYBOARD) begin
        status[ST_KEYBOARD] = 1'b1;
      end
    end
    if (id_line_d == LEVEL_ATTACHED) begin
      if (acc_type_d == ACC_CAR_HOLDER) begin
        status[ST_CARMOUNT] = 1'b1;
      end else if (acc_type_d == ACC_TV) begin
        status[ST_TV] = 1'b1;
      end else if (acc_type_d == ACC_AUDIO_OUT) begin
        status[ST_LINEOUT] = 1'b1;
      end
    end
    status[ST_HPD] = in_i.payload.hpd_active;

    out_d.event_kind      = ev;
    out_d.event_online    = online;
    out_d.dock_kind       = dock_detached ? dock_type_q : dock_type_d;
    out_d.accessory_kind  = acc_type_d;
    out_d.usb_host_attach = usb;
    out_d.tv_power        = tv_power_d;
    out_d.status_bits     = status;
    out_d.averaged_adc    = last_mean_d;
  end

  // Control state: advance only on an accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dock_line_q <= DOCK_LINE_UNSEEN;
      id_line_q   <= LEVEL_DETACHED;
      dock_type_q <= DOCK_NONE;
      acc_type_q  <= ACC_UNKNOWN;
      samples_q   <= '0;
      sampling_q  <= 1'b0;
      sum_q       <= '0;
      min_q       <= '0;
      max_q       <= '0;
      tv_power_q  <= 1'b0;
      last_mean_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        dock_line_q <= dock_line_d;
        id_line_q   <= id_line_d;
        dock_type_q <= dock_type_d;
        acc_type_q  <= acc_type_d;
        samples_q   <= samples_d;
        sampling_q  <= sampling_d;
        sum_q       <= sum_d;
        min_q       <= min_d;
        max_q       <= max_d;
        tv_power_q  <= tv_power_d;
        last_mean_q <= last_mean_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load with each accepted beat, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `ADD_ASSERT_IMP(a_usb_needs_online,
    out_valid_q && out_q.usb_host_attach,
    out_q.event_kind == EVT_ACCESSORY && out_q.event_online,
    "USB host flag without an accessory attach")
  `ADD_ASSERT_IMP(a_count_needs_sampling,
    samples_q != '0,
    sampling_q,
    "sample count nonzero while not sampling")
  `ADD_ASSERT_IMP(a_tv_power_on_beat,
    $rose(tv_power_q),
    $past(in_fire),
    "TV supply rose without an accepted beat")
  `ADD_ASSERT_NXT(a_dock_detach_clears,
    in_fire && in_i.payload.operation == OP_DOCK_LINE &&
      in_i.payload.line_level == LEVEL_DETACHED,
    dock_type_q == DOCK_NONE,
    "dock type kept after dock line went high")

endmodule

`default_nettype wire
